@@ rtl/assert_macros.svh @@
// Assertion shorthands used by the checker file vfc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vfc_pkg.sv @@
package vfc_pkg;

    localparam int HEIGHT_W = 7;
    localparam int AO_W     = 9;
    localparam int NUM_FACE = 6;
    localparam int NUM_CORN = 4;

    // 5x5 column window around the queried column
    localparam int WIN_SIDE = 5;
    localparam int WIN_HALF = 2;
    localparam int WIN_N    = WIN_SIDE * WIN_SIDE;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [HEIGHT_W-1:0] height_t;
    typedef logic [AO_W-1:0]     ao_t;
    typedef logic [4:0]          win_idx_t;
    typedef logic [2:0]          win_cnt_t;
    typedef logic [2:0]          face_t;
    typedef logic [NUM_FACE-1:0] vis_t;

    typedef logic [WIN_N-1:0][HEIGHT_W-1:0] win_t;
    typedef logic [NUM_FACE-1:0][NUM_CORN-1:0][AO_W-1:0] ao_set_t;

    typedef struct packed {
        vis_t    vis;
        ao_set_t ao;
    } face_eval_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EVAL,
        ST_EMIT
    } state_t;

    localparam win_cnt_t WIN_LAST = 3'(WIN_SIDE - 1);

    // Brightness by {side1, side2, corner, diagonal} solid bits
    localparam ao_t BRIGHT_TAB [16] = '{
        9'd256, 9'd219, 9'd243, 9'd243,
        9'd220, 9'd202, 9'd214, 9'd214,
        9'd220, 9'd202, 9'd214, 9'd214,
        9'd154, 9'd154, 9'd154, 9'd154
    };

    // Per face, per corner: side1 (dx,dy,dz), side2 (dx,dy,dz)
    localparam logic signed [2:0] CORNER_OFFS [NUM_FACE][NUM_CORN][6] = '{
        '{ '{-3'sd1, 3'sd0, 3'sd1,  3'sd0, 3'sd1, 3'sd1},
           '{ 3'sd1, 3'sd0, 3'sd1,  3'sd0, 3'sd1, 3'sd1},
           '{-3'sd1, 3'sd0, 3'sd1,  3'sd0,-3'sd1, 3'sd1},
           '{ 3'sd1, 3'sd0, 3'sd1,  3'sd0,-3'sd1, 3'sd1} },
        '{ '{ 3'sd1, 3'sd0, 3'sd1,  3'sd1, 3'sd1, 3'sd0},
           '{ 3'sd1, 3'sd0,-3'sd1,  3'sd1, 3'sd1, 3'sd0},
           '{ 3'sd1, 3'sd0, 3'sd1,  3'sd1,-3'sd1, 3'sd0},
           '{ 3'sd1, 3'sd0,-3'sd1,  3'sd1,-3'sd1, 3'sd0} },
        '{ '{ 3'sd1, 3'sd0,-3'sd1,  3'sd0, 3'sd1,-3'sd1},
           '{-3'sd1, 3'sd0,-3'sd1,  3'sd0, 3'sd1,-3'sd1},
           '{ 3'sd1, 3'sd0,-3'sd1,  3'sd0,-3'sd1,-3'sd1},
           '{-3'sd1, 3'sd0,-3'sd1,  3'sd0,-3'sd1,-3'sd1} },
        '{ '{-3'sd1, 3'sd0,-3'sd1, -3'sd1, 3'sd1, 3'sd0},
           '{-3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd1, 3'sd0},
           '{-3'sd1, 3'sd0,-3'sd1, -3'sd1,-3'sd1, 3'sd0},
           '{-3'sd1, 3'sd0, 3'sd1, -3'sd1,-3'sd1, 3'sd0} },
        '{ '{-3'sd1, 3'sd1, 3'sd0,  3'sd0, 3'sd1,-3'sd1},
           '{ 3'sd1, 3'sd1, 3'sd0,  3'sd0, 3'sd1,-3'sd1},
           '{-3'sd1, 3'sd1, 3'sd0,  3'sd0, 3'sd1, 3'sd1},
           '{ 3'sd1, 3'sd1, 3'sd0,  3'sd0, 3'sd1, 3'sd1} },
        '{ '{-3'sd1,-3'sd1, 3'sd0,  3'sd0,-3'sd1,-3'sd1},
           '{ 3'sd1,-3'sd1, 3'sd0,  3'sd0,-3'sd1,-3'sd1},
           '{-3'sd1,-3'sd1, 3'sd0,  3'sd0,-3'sd1, 3'sd1},
           '{ 3'sd1,-3'sd1, 3'sd0,  3'sd0,-3'sd1, 3'sd1} }
    };

    // Window slot of column offset (dx, dz); read order is dx outer, dz inner
    function automatic win_idx_t win_idx(input int dx, input int dz);
        return win_idx_t'((dx + WIN_HALF) * WIN_SIDE + dz + WIN_HALF);
    endfunction

endpackage

@@ rtl/vfc_ram.sv @@
module vfc_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 400
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/vfc_face_eval.sv @@
module vfc_face_eval
    import vfc_pkg::*;
#(
    parameter int CHUNK_H = 64
) (
    input  win_t       win,
    input  height_t    voxel_y,
    output face_eval_t result
);

    localparam height_t CAP = height_t'(CHUNK_H - 1);

    // Position is solid when its y is not above the capped column height
    function automatic logic solid(input height_t h, input height_t y, input int dy);
        height_t           hc;
        logic signed [8:0] yy;
        hc = (h > CAP) ? CAP : h;
        yy = $signed({2'b00, y}) + 9'(dy);
        return yy <= $signed({2'b00, hc});
    endfunction

    always_comb
    begin
        int s1x, s1y, s1z, s2x, s2y, s2z;
        logic [3:0] key;
        result.vis[0] = voxel_y > win[win_idx(0, 1)];
        result.vis[1] = voxel_y > win[win_idx(1, 0)];
        result.vis[2] = voxel_y > win[win_idx(0, -1)];
        result.vis[3] = voxel_y > win[win_idx(-1, 0)];
        result.vis[4] = voxel_y == win[win_idx(0, 0)];
        result.vis[5] = voxel_y == '0;
        for (int f = 0; f < NUM_FACE; f++)
        begin
            for (int c = 0; c < NUM_CORN; c++)
            begin
                s1x = int'(CORNER_OFFS[f][c][0]);
                s1y = int'(CORNER_OFFS[f][c][1]);
                s1z = int'(CORNER_OFFS[f][c][2]);
                s2x = int'(CORNER_OFFS[f][c][3]);
                s2y = int'(CORNER_OFFS[f][c][4]);
                s2z = int'(CORNER_OFFS[f][c][5]);
                key[3] = solid(win[win_idx(s1x, s1z)], voxel_y, s1y);
                key[2] = solid(win[win_idx(s2x, s2z)], voxel_y, s2y);
                key[1] = solid(win[win_idx(s1x + s2x, s1z + s2z)], voxel_y, s1y + s2y);
                // one below the corner position
                key[0] = solid(win[win_idx(s1x + s2x, s1z + s2z)], voxel_y,
                               s1y + s2y - 1);
                result.ao[3'(f)][2'(c)] = BRIGHT_TAB[key];
            end
        end
    end

endmodule

@@ rtl/voxel_face_cull_and_ao_unit.sv @@
// Channel   | Words                                   | Handshake
// ----------+-----------------------------------------+--------------------------
// in        | opcode col_x col_z voxel_y height_value | in_valid / in_stall
// out       | face_index ao_* last_face               | out_valid / out_stall
// cfg       | cfg_data (sea level)                    | cfg_valid / cfg_ready
//
// A load is one write to the single-port height RAM.
// A query holds in_stall through 25 column reads of the 5x5 window on the
// RAM port, a drain state for the read latency, an evaluation state, then
// each visible face into the output register, one per cycle unless stalled.
// An out_stall holds the face sequence; the last word may wait in the output
// register while the next item is taken. Reset clears control only; the RAM
// holds no valid state and needs no clearing pass.
module voxel_face_cull_and_ao_unit
    import vfc_pkg::*;
#(
    parameter int CHUNK_W = 16,
    parameter int CHUNK_D = 16,
    parameter int CHUNK_H = 64,
    parameter int BORDER  = 4
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [4:0] col_x,
    input  logic [4:0] col_z,
    input  logic [6:0] voxel_y,
    input  logic [7:0] height_value,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] face_index,
    output logic [8:0] ao_top_left,
    output logic [8:0] ao_top_right,
    output logic [8:0] ao_bottom_left,
    output logic [8:0] ao_bottom_right,
    output logic       last_face,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);

    localparam int GRID_W = CHUNK_W + BORDER;
    localparam int GRID_D = CHUNK_D + BORDER;
    localparam int GRID_N = GRID_W * GRID_D;
    localparam int ADDR_W = $clog2(GRID_N);
    localparam int HALF_B = BORDER / 2;

    localparam logic [7:0] CHUNK_W8 = 8'(CHUNK_W);
    localparam logic [7:0] CHUNK_D8 = 8'(CHUNK_D);
    localparam logic [7:0] GRID_W8  = 8'(GRID_W);
    localparam logic [7:0] GRID_D8  = 8'(GRID_D);
    localparam logic [7:0] CHUNK_H8 = 8'(CHUNK_H);
    localparam logic [7:0] WIN_OFS  = 8'(HALF_B - WIN_HALF);
    localparam height_t    SEA_RST  = 7'd5;

    state_t state_reg, state_next;

    height_t    sea_level_reg;
    logic [4:0] x_reg, z_reg;
    height_t    y_reg;
    win_cnt_t   u_reg, u_next;
    win_cnt_t   w_reg, w_next;
    logic       rd_pend_reg;
    win_t       win_reg;
    face_eval_t eval_reg;
    face_eval_t eval_comb;
    vis_t       rem_reg, rem_next;

    logic       out_valid_reg;
    face_t      face_reg;
    ao_t        ao_tl_reg, ao_tr_reg, ao_bl_reg, ao_br_reg;
    logic       last_reg;

    logic              in_acc;
    logic              query_go;
    logic              load_ok;
    logic              ram_we;
    logic              reading;
    logic [ADDR_W-1:0] ram_addr;
    height_t           ram_wdata;
    height_t           ram_rdata;
    logic [7:0]        hv_clamp;
    logic [7:0]        rd_bx, rd_bz;
    logic              emit_fire;
    face_t             sel_face;

    assign in_acc   = in_valid && !in_stall;
    assign query_go = in_acc && (opcode == OP_QUERY)
                      && ({3'b000, col_x} < CHUNK_W8) && ({3'b000, col_z} < CHUNK_D8);
    assign load_ok  = ({3'b000, col_x} < GRID_W8) && ({3'b000, col_z} < GRID_D8);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sea_level_reg <= SEA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sea_level_reg <= cfg_data;
        end
    end

    // load clamp: sea level first, then chunk height
    always_comb
    begin
        hv_clamp = height_value;
        if (hv_clamp < {1'b0, sea_level_reg})
        begin
            hv_clamp = {1'b0, sea_level_reg};
        end
        if (hv_clamp > CHUNK_H8)
        begin
            hv_clamp = CHUNK_H8;
        end
    end

    assign rd_bx     = 8'(x_reg) + WIN_OFS + 8'(u_reg);
    assign rd_bz     = 8'(z_reg) + WIN_OFS + 8'(w_reg);
    assign ram_wdata = hv_clamp[6:0];

    always_comb
    begin
        if (reading)
        begin
            ram_addr = ADDR_W'(rd_bx * GRID_D + rd_bz);
        end
        else
        begin
            ram_addr = ADDR_W'(col_x * GRID_D + col_z);
        end
    end

    vfc_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (GRID_N)
    ) u_height_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vfc_face_eval #(
        .CHUNK_H (CHUNK_H)
    ) u_face_eval (
        .win     (win_reg),
        .voxel_y (y_reg),
        .result  (eval_comb)
    );

    // lowest remaining visible face
    always_comb
    begin
        sel_face = '0;
        for (int i = NUM_FACE - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                sel_face = face_t'(i);
            end
        end
    end

    assign rem_next = rem_reg & ~(vis_t'(1) << sel_face);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (u_reg == WIN_LAST && w_reg == WIN_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = (eval_comb.vis == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire && rem_next == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        reading   = 1'b0;
        emit_fire = 1'b0;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_we   = in_acc && (opcode == OP_LOAD) && load_ok;
            end
            ST_READ:
            begin
                reading = 1'b1;
            end
            ST_DRAIN, ST_EVAL:
            begin
                in_stall = 1'b1;
            end
            ST_EMIT:
            begin
                emit_fire = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // window scan counters, dz inner
    always_comb
    begin
        u_next = u_reg;
        w_next = w_reg;
        if (query_go)
        begin
            u_next = '0;
            w_next = '0;
        end
        else if (reading)
        begin
            if (w_reg == WIN_LAST)
            begin
                w_next = '0;
                u_next = u_reg + 3'd1;
            end
            else
            begin
                w_next = w_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            u_reg         <= '0;
            w_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            u_reg       <= u_next;
            w_reg       <= w_next;
            rd_pend_reg <= reading;
            if (state_reg == ST_EVAL)
            begin
                rem_reg <= eval_comb.vis;
            end
            else if (emit_fire)
            begin
                rem_reg <= rem_next;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            x_reg <= col_x;
            z_reg <= col_z;
            y_reg <= voxel_y;
        end
        // read data lands in the cycle after its address
        if (rd_pend_reg)
        begin
            win_reg <= {ram_rdata, win_reg[WIN_N-1:1]};
        end
        if (state_reg == ST_EVAL)
        begin
            eval_reg <= eval_comb;
        end
        if (emit_fire)
        begin
            face_reg  <= sel_face;
            ao_tl_reg <= eval_reg.ao[sel_face][0];
            ao_tr_reg <= eval_reg.ao[sel_face][1];
            ao_bl_reg <= eval_reg.ao[sel_face][2];
            ao_br_reg <= eval_reg.ao[sel_face][3];
            last_reg  <= (rem_next == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign face_index      = face_reg;
    assign ao_top_left     = ao_tl_reg;
    assign ao_top_right    = ao_tr_reg;
    assign ao_bottom_left  = ao_bl_reg;
    assign ao_bottom_right = ao_br_reg;
    assign last_face       = last_reg;

endmodule

@@ rtl/vfc_checker.sv @@
`include "assert_macros.svh"

module vfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] face_index,
    input logic       last_face
);

    `VFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")

    `VFC_ASSERT_NOW(a_face_range, out_valid, face_index <= 3'd5, "face index out of range")

    // faces of one voxel come back to back in ascending order
    `VFC_ASSERT_NEXT(a_face_order, out_valid && !out_stall && !last_face, out_valid && face_index > $past(face_index), "face sequence broken")

    // no new item while faces of the current voxel are still pending
    `VFC_ASSERT_NOW(a_busy_stall, out_valid && !last_face, in_stall, "input taken mid voxel")

endmodule

bind voxel_face_cull_and_ao_unit vfc_checker u_vfc_checker (.*);

@@ sim/face_ao_checker.sv @@
`timescale 1ns / 1ps

module face_ao_checker
    import vfc_pkg::*;
#(
    parameter int CHUNK_W = 16,
    parameter int CHUNK_D = 16,
    parameter int CHUNK_H = 64,
    parameter int BORDER  = 4
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       opcode,
    input  logic [4:0] col_x,
    input  logic [4:0] col_z,
    input  logic [6:0] voxel_y,
    input  logic [7:0] height_value,

    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] face_index,
    input  logic [8:0] ao_top_left,
    input  logic [8:0] ao_top_right,
    input  logic [8:0] ao_bottom_left,
    input  logic [8:0] ao_bottom_right,
    input  logic       last_face,

    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [6:0] cfg_data,

    output int         mismatches,
    output int         pending_words
);

    localparam int GRID_W = CHUNK_W + BORDER;
    localparam int GRID_D = CHUNK_D + BORDER;
    localparam int HALF_B = BORDER / 2;

    localparam int FACE_POS_Z = 0;
    localparam int FACE_POS_X = 1;
    localparam int FACE_NEG_Z = 2;
    localparam int FACE_NEG_X = 3;
    localparam int FACE_POS_Y = 4;

    typedef struct packed {
        logic [2:0] face;
        logic [8:0] tl;
        logic [8:0] tr;
        logic [8:0] bl;
        logic [8:0] br;
        logic       last;
    } face_word_t;

    face_word_t   expected_faces [$];
    face_word_t   exp_w;
    face_word_t   got_w;
    logic [6:0]   sea_level_q = 7'd5;
    logic [6:0]   col_heights [GRID_W][GRID_D];
    int           fail_count = 0;

    // chunk coordinates, border included
    function automatic int column_height(input int x, input int z);
        int bx;
        int bz;
        bx = x + HALF_B;
        bz = z + HALF_B;
        if (bx < 0 || bx >= GRID_W || bz < 0 || bz >= GRID_D)
            return 0;
        return int'(col_heights[bx][bz]);
    endfunction

    function automatic bit solid_at(input int x, input int y, input int z);
        int h;
        h = column_height(x, z);
        if (h > CHUNK_H - 1)
            h = CHUNK_H - 1;
        return y <= h;
    endfunction

    // Side 1 steps along the first tangent, side 2 along the second; both carry
    // the normal, so the corner sits two steps out along it.
    function automatic logic [8:0] corner_light(input int x, input int y, input int z,
                                                input int f, input int c);
        int nx, ny, nz;
        int sg1, sg2;
        int ax, ay, az, bx, by, bz;
        bit s1, s2, cr, dg;
        nx = 0;
        ny = 0;
        nz = 0;
        case (f)
            FACE_POS_Z: nz = 1;
            FACE_POS_X: nx = 1;
            FACE_NEG_Z: nz = -1;
            FACE_NEG_X: nx = -1;
            FACE_POS_Y: ny = 1;
            default:    ny = -1;
        endcase
        sg1 = (c % 2 == 1) ? 1 : -1;
        if (f == FACE_POS_X || f == FACE_NEG_Z)
            sg1 = -sg1;
        sg2 = (c < 2) ? 1 : -1;
        if (f >= FACE_POS_Y)
            sg2 = -sg2;
        ax = nx; ay = ny; az = nz;
        bx = nx; by = ny; bz = nz;
        if (f == FACE_POS_X || f == FACE_NEG_X)
            az = az + sg1;
        else
            ax = ax + sg1;
        if (f >= FACE_POS_Y)
            bz = bz + sg2;
        else
            by = by + sg2;
        s1 = solid_at(x + ax, y + ay, z + az);
        s2 = solid_at(x + bx, y + by, z + bz);
        cr = solid_at(x + ax + bx, y + ay + by, z + az + bz);
        dg = solid_at(x + ax + bx, y + ay + by - 1, z + az + bz);
        if (s1 && s2)
            return 9'd154;
        if (s1 || s2)
            return cr ? 9'd214 : (dg ? 9'd202 : 9'd220);
        return cr ? 9'd243 : (dg ? 9'd219 : 9'd256);
    endfunction

    task automatic predict_faces(input logic op, input int x, input int z,
                                 input int y, input int hv);
        int h;
        logic [5:0] vis;
        face_word_t w;
        if (op == OP_LOAD)
        begin
            if (x < GRID_W && z < GRID_D)
            begin
                h = hv;
                if (h < int'(sea_level_q))
                    h = int'(sea_level_q);
                if (h > CHUNK_H)
                    h = CHUNK_H;
                col_heights[x][z] = 7'(h);
            end
            return;
        end
        if (x >= CHUNK_W || z >= CHUNK_D)
            return;
        vis[0] = y > column_height(x, z + 1);
        vis[1] = y > column_height(x + 1, z);
        vis[2] = y > column_height(x, z - 1);
        vis[3] = y > column_height(x - 1, z);
        vis[4] = y == column_height(x, z);
        vis[5] = y == 0;
        for (int f = 0; f < 6; f++)
        begin
            if (vis[f])
            begin
                w.face = 3'(f);
                w.tl   = corner_light(x, y, z, f, 0);
                w.tr   = corner_light(x, y, z, f, 1);
                w.bl   = corner_light(x, y, z, f, 2);
                w.br   = corner_light(x, y, z, f, 3);
                w.last = (vis >> (f + 1)) == 0;
                expected_faces = {expected_faces, w};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sea_level_q = 7'd5;
            expected_faces.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_w = {face_index, ao_top_left, ao_top_right, ao_bottom_left,
                         ao_bottom_right, last_face};
                if (expected_faces.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected face word: face %0d ao %0d %0d %0d %0d last %0b",
                                 got_w.face, got_w.tl, got_w.tr, got_w.bl, got_w.br,
                                 got_w.last);
                end
                else
                begin
                    exp_w = expected_faces.pop_front();
                    if (got_w != exp_w)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("face word mismatch, expected face %0d ao %0d %0d %0d %0d last %0b",
                                     exp_w.face, exp_w.tl, exp_w.tr, exp_w.bl, exp_w.br,
                                     exp_w.last);
                            $display("                    got      face %0d ao %0d %0d %0d %0d last %0b",
                                     got_w.face, got_w.tl, got_w.tr, got_w.bl, got_w.br,
                                     got_w.last);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                sea_level_q = cfg_data;
            if (in_valid && !in_stall)
                predict_faces(opcode, int'(col_x), int'(col_z), int'(voxel_y),
                              int'(height_value));
        end
        pending_words <= expected_faces.size();
        mismatches    <= fail_count;
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import vfc_pkg::*;

    localparam int CHUNK_W = 16;
    localparam int CHUNK_D = 16;
    localparam int CHUNK_H = 64;
    localparam int BORDER  = 4;
    localparam int GRID_W  = CHUNK_W + BORDER;
    localparam int GRID_D  = CHUNK_D + BORDER;

    // two corner blocks of columns are loaded; queries stay inside them
    localparam int BLOCK_SPAN = 7;
    localparam int QUERY_SPAN = 3;

    localparam int TIMEOUT_CYCLES = 150000;
    localparam int LONG_HOLD      = 300;
    localparam int QUIET_CYCLES   = 40;
    localparam int DRAIN_WAIT     = 60;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       opcode = OP_LOAD;
    logic [4:0] col_x = '0;
    logic [4:0] col_z = '0;
    logic [6:0] voxel_y = '0;
    logic [7:0] height_value = '0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] face_index;
    logic [8:0] ao_top_left;
    logic [8:0] ao_top_right;
    logic [8:0] ao_bottom_left;
    logic [8:0] ao_bottom_right;
    logic       last_face;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;

    int         mismatches;
    int         pending_words;
    int         cycle_count = 0;
    bit         no_idle = 1'b0;
    bit         long_hold_req = 1'b0;

    voxel_face_cull_and_ao_unit #(
        .CHUNK_W(CHUNK_W),
        .CHUNK_D(CHUNK_D),
        .CHUNK_H(CHUNK_H),
        .BORDER (BORDER)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .col_x          (col_x),
        .col_z          (col_z),
        .voxel_y        (voxel_y),
        .height_value   (height_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .face_index     (face_index),
        .ao_top_left    (ao_top_left),
        .ao_top_right   (ao_top_right),
        .ao_bottom_left (ao_bottom_left),
        .ao_bottom_right(ao_bottom_right),
        .last_face      (last_face),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    face_ao_checker #(
        .CHUNK_W(CHUNK_W),
        .CHUNK_D(CHUNK_D),
        .CHUNK_H(CHUNK_H),
        .BORDER (BORDER)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .col_x          (col_x),
        .col_z          (col_z),
        .voxel_y        (voxel_y),
        .height_value   (height_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .face_index     (face_index),
        .ao_top_left    (ao_top_left),
        .ao_top_right   (ao_top_right),
        .ao_bottom_left (ao_bottom_left),
        .ao_bottom_right(ao_bottom_right),
        .last_face      (last_face),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending_words  (pending_words)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("FAIL voxel_face_cull_and_ao_unit");
            $finish;
        end
    end

    // output side: random stall before each word, one long hold-off on request
    initial
    begin : face_sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
            begin
                hold = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // leaves in_valid high after the accept so a gapless word can follow
    task automatic send_word(input logic op, input logic [4:0] x, input logic [4:0] z,
                             input logic [6:0] y, input logic [7:0] hv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        col_x        <= x;
        col_z        <= z;
        voxel_y      <= y;
        height_value <= hv;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_faces();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    task automatic write_sea_level(input logic [6:0] level);
        drain_faces();
        // a query with no visible face may still be running
        repeat (QUIET_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // block A: low x, high z; block B: high x, low z
    task automatic pick_column(output int bx, output int bz);
        int r1;
        int r2;
        r1 = $urandom_range(0, BLOCK_SPAN - 1);
        r2 = $urandom_range(0, BLOCK_SPAN - 1);
        if ($urandom_range(0, 1) == 1)
        begin
            bx = GRID_W - BLOCK_SPAN + r1;
            bz = r2;
        end
        else
        begin
            bx = r1;
            bz = GRID_D - BLOCK_SPAN + r2;
        end
    endtask

    // voxel whose whole 5x5 window lies in one loaded block
    task automatic pick_voxel(output int x, output int z);
        int r1;
        int r2;
        r1 = $urandom_range(0, QUERY_SPAN - 1);
        r2 = $urandom_range(0, QUERY_SPAN - 1);
        if ($urandom_range(0, 1) == 1)
        begin
            x = CHUNK_W - QUERY_SPAN + r1;
            z = r2;
        end
        else
        begin
            x = r1;
            z = CHUNK_D - QUERY_SPAN + r2;
        end
    endtask

    task automatic fill_columns(input int base);
        int bx;
        int bz;
        for (int blk = 0; blk < 2; blk++)
        begin
            for (int i = 0; i < BLOCK_SPAN; i++)
            begin
                for (int j = 0; j < BLOCK_SPAN; j++)
                begin
                    bx = (blk == 1) ? GRID_W - BLOCK_SPAN + i : i;
                    bz = (blk == 1) ? j : GRID_D - BLOCK_SPAN + j;
                    send_word(OP_LOAD, 5'(bx), 5'(bz), 7'($urandom_range(0, 127)),
                              8'(base + $urandom_range(0, 7)));
                end
            end
        end
    endtask

    // heights mostly in a narrow band so that y lands on faces often
    task automatic random_mix(input int count, input int base);
        int done;
        int r;
        int x, z, y, hv;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                drain_faces();
            end
            else if (r < 28)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // off the buffered grid: ignored
                    if ($urandom_range(0, 1) == 1)
                    begin
                        x = $urandom_range(GRID_W, 31);
                        z = $urandom_range(0, 31);
                    end
                    else
                    begin
                        x = $urandom_range(0, 31);
                        z = $urandom_range(GRID_D, 31);
                    end
                end
                else
                begin
                    pick_column(x, z);
                end
                hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : base + $urandom_range(0, 7);
                send_word(OP_LOAD, 5'(x), 5'(z), 7'($urandom_range(0, 127)), 8'(hv));
                done++;
            end
            else
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    x = $urandom_range(0, 31);
                    z = $urandom_range(CHUNK_D, 31);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        x = z;
                        z = $urandom_range(0, 31);
                    end
                end
                else
                begin
                    pick_voxel(x, z);
                end
                r = $urandom_range(0, 19);
                if (r < 2)
                    y = 0;
                else if (r < 5)
                    y = $urandom_range(0, 127);
                else
                    y = base - 1 + $urandom_range(0, 10);
                if (y < 0)
                    y = 0;
                send_word(OP_QUERY, 5'(x), 5'(z), 7'(y), 8'($urandom_range(0, 255)));
                done++;
            end
        end
    endtask

    initial
    begin : stimulus
        int level;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every column a query window can reach is written first
        fill_columns(5);

        // directed words
        send_word(OP_LOAD,  5'd2,  5'd15, 7'd0,   8'd255);  // clamps to chunk height
        send_word(OP_QUERY, 5'd0,  5'd13, 7'd64,  8'd0);    // top at chunk height
        send_word(OP_QUERY, 5'd0,  5'd13, 7'd0,   8'd0);    // bottom face only
        send_word(OP_QUERY, 5'd0,  5'd13, 7'd63,  8'd0);
        send_word(OP_LOAD,  5'd2,  5'd15, 7'd127, 8'd0);    // raised to sea level
        send_word(OP_QUERY, 5'd0,  5'd13, 7'd5,   8'd0);
        send_word(OP_LOAD,  5'd16, 5'd3,  7'd0,   8'd20);
        send_word(OP_QUERY, 5'd14, 5'd1,  7'd20,  8'd0);
        send_word(OP_QUERY, 5'd14, 5'd1,  7'd21,  8'd255);
        send_word(OP_QUERY, 5'd14, 5'd1,  7'd5,   8'd0);    // nothing shows
        send_word(OP_LOAD,  5'd17, 5'd3,  7'd0,   8'd64);
        send_word(OP_LOAD,  5'd16, 5'd4,  7'd0,   8'd63);
        send_word(OP_QUERY, 5'd14, 5'd1,  7'd20,  8'd0);
        send_word(OP_QUERY, 5'd15, 5'd1,  7'd13,  8'd0);
        send_word(OP_LOAD,  5'd20, 5'd0,  7'd0,   8'd40);   // off the grid
        send_word(OP_LOAD,  5'd0,  5'd20, 7'd0,   8'd40);
        send_word(OP_LOAD,  5'd31, 5'd31, 7'd127, 8'd255);
        send_word(OP_QUERY, 5'd16, 5'd0,  7'd127, 8'd0);    // outside the chunk
        send_word(OP_QUERY, 5'd0,  5'd16, 7'd127, 8'd0);
        send_word(OP_QUERY, 5'd31, 5'd31, 7'd127, 8'd255);
        send_word(OP_QUERY, 5'd15, 5'd0,  7'd127, 8'd0);    // chunk edges
        send_word(OP_QUERY, 5'd2,  5'd15, 7'd0,   8'd0);
        send_word(OP_QUERY, 5'd0,  5'd15, 7'd1,   8'd0);

        // back-to-back words against a long output hold-off
        long_hold_req = 1'b1;
        no_idle = 1'b1;
        random_mix(25, 5);
        no_idle = 1'b0;
        random_mix(20, 5);

        write_sea_level(7'd0);
        random_mix(25, 0);

        write_sea_level(7'd64);
        random_mix(20, 58);

        // sea level above chunk height
        write_sea_level(7'd127);
        random_mix(20, 58);

        level = $urandom_range(1, 63);
        write_sea_level(7'(level));
        random_mix(20, level);

        drain_faces();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_words == 0)
            $display("PASS voxel_face_cull_and_ao_unit");
        else
            $display("FAIL voxel_face_cull_and_ao_unit");
        $finish;
    end

endmodule
